@@ design/ihe_pkg.sv @@
// Package for the image histogram entropy block.
// Holds shared widths, constants, codes and the sequencer state type.
// No dependencies.
package ihe_pkg;

  localparam int BIN_COUNT   = 256;
  localparam int BIN_W       = 8;
  localparam int MAX_PIXELS  = 4194304;
  localparam int PIXEL_W     = 18;
  localparam int ENTROPY_W   = 19;
  localparam int COUNT_OUT_W = 23;
  localparam int PROB_W      = 17;
  localparam int ONE_Q16     = 65536;
  localparam int ENTROPY_MAX = 393215;
  localparam logic [31:0] LN2_Q32 = 32'd2977044472;

  localparam logic FUNC_ACCUM = 1'b0;
  localparam logic FUNC_READ  = 1'b1;
  localparam logic KIND_SUMMARY = 1'b0;
  localparam logic KIND_ANSWER  = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ACC,
    ST_RD,
    ST_DIV,
    ST_E_ADDR,
    ST_E_DATA,
    ST_LG_NORM,
    ST_LG_SQ,
    ST_LG_BIT,
    ST_CL_MUL,
    ST_CL_ADD,
    ST_NL_MUL,
    ST_NL_SUB,
    ST_LN_MUL,
    ST_LN_OUT
  } state_t;

endpackage

@@ design/ihe_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Used for the histogram store; depends on nothing.
module ihe_ram #(
  parameter int WIDTH = 23,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ design/image_histogram_entropy.sv @@
// Pixel accumulate: each word passes through the ACC state. Bin read: straight back to idle
// with an empty frame, else through the shared 48-step divider (one quotient bit a cycle).
// Frame summary after the last pixel: an address and a data state per empty bin; per
// occupied bin also a normalize shift plus 16 square steps on the shared multiplier,
// then the log of the pixel count, a 48-step divide and the ln 2 scaling.
// Synchronous reset clears the control state and the histogram valid bits;
// results come out on a one-cycle done strobe that the receiver cannot stall.
module image_histogram_entropy #(
  parameter int MAX_PIXELS = ihe_pkg::MAX_PIXELS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic                               func,
  input  logic signed [ihe_pkg::PIXEL_W-1:0] pixel,
  input  logic                               last,
  input  logic [ihe_pkg::BIN_W-1:0]          bin_index,
  output logic                               done,
  output logic                               kind,
  output logic [ihe_pkg::ENTROPY_W-1:0]      entropy,
  output logic                               out_of_range,
  output logic [ihe_pkg::COUNT_OUT_W-1:0]    pixel_count,
  output logic [ihe_pkg::PROB_W-1:0]         probability
);

  // Count width follows from the frame capacity.
  localparam int CW   = $clog2(MAX_PIXELS + 1);
  // Dividend width of the shared divider; holds both count * 2^16 and the
  // weighted log sum.
  localparam int DIVW = 48;
  localparam int DCW  = $clog2(DIVW);
  localparam logic [ihe_pkg::BIN_W-1:0] LAST_BIN = ihe_pkg::BIN_W'(ihe_pkg::BIN_COUNT - 1);

  ihe_pkg::state_t state, state_next;

  // Frame state.
  logic [CW-1:0]                  frame_pixels;
  logic                           clamp_seen;
  logic                           frame_open;
  logic [ihe_pkg::BIN_COUNT-1:0]  valid;
  logic                           last_q;

  // Histogram access.
  logic [ihe_pkg::BIN_W-1:0]      addr;
  logic [ihe_pkg::BIN_W-1:0]      raddr;
  logic [CW-1:0]                  rdata;
  logic [CW-1:0]                  cnt_now;
  logic                           ram_we;

  // Entropy walk.
  logic [ihe_pkg::BIN_W-1:0]      idx;
  logic [CW-1:0]                  c_q;
  logic [DIVW-1:0]                sub;
  logic                           lg_total;

  // Log unit: mantissa, exponent and fraction bits.
  logic [30:0]                    m;
  logic [4:0]                     lg_e;
  logic [15:0]                    lg_f;
  logic [3:0]                     k;
  logic [31:0]                    mq;

  // Shared multiplier with a registered product.
  logic [31:0]                    mul_a, mul_b;
  logic [63:0]                    prod;

  // Shared restoring divider.
  logic [DIVW-1:0]                dvd, dvd_next;
  logic [CW:0]                    rem, rem_shift, rem_next;
  logic [CW-1:0]                  dsr;
  logic [DCW-1:0]                 dcnt;
  logic                           div_ent;

  // Pixel clamp and bin select.
  logic                           pix_neg, pix_over, pix_clamp;
  logic [16:0]                    pix_y;
  logic [24:0]                    pix_y255;
  logic [ihe_pkg::BIN_W-1:0]      pix_bin;

  logic [DIVW-1:0]                t_val;
  logic [31:0]                    h_val;

  assign pix_neg   = pixel[ihe_pkg::PIXEL_W-1];
  assign pix_over  = !pix_neg && (pixel > ihe_pkg::PIXEL_W'(ihe_pkg::ONE_Q16));
  assign pix_clamp = pix_neg || pix_over;
  assign pix_y     = pix_neg ? 17'd0 : (pix_over ? 17'(ihe_pkg::ONE_Q16) : pixel[16:0]);
  // 255 * y written as 256 * y - y.
  assign pix_y255  = {pix_y, 8'd0} - {8'd0, pix_y};
  assign pix_bin   = pix_y255[23:16];

  // A bin whose valid bit is clear has not been touched this frame and reads as zero.
  assign cnt_now = valid[addr] ? rdata : '0;

  assign ram_we = (state == ihe_pkg::ST_ACC) && (frame_pixels < CW'(MAX_PIXELS));

  always_comb begin
    raddr = addr;
    case (state)
      ihe_pkg::ST_IDLE:   raddr = (func == ihe_pkg::FUNC_READ) ? bin_index : pix_bin;
      ihe_pkg::ST_E_ADDR: raddr = idx;
      default:            raddr = addr;
    endcase
  end

  ihe_ram #(
    .WIDTH(CW),
    .DEPTH(ihe_pkg::BIN_COUNT)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(addr),
    .wdata(cnt_now + CW'(1)),
    .raddr(raddr),
    .rdata(rdata)
  );

  // Operand select for the one multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      ihe_pkg::ST_LG_SQ: begin
        mul_a = {1'b0, m};
        mul_b = {1'b0, m};
      end
      ihe_pkg::ST_CL_MUL: begin
        mul_a = 32'(c_q);
        mul_b = 32'({lg_e, lg_f});
      end
      ihe_pkg::ST_NL_MUL: begin
        mul_a = 32'(frame_pixels);
        mul_b = 32'({lg_e, lg_f});
      end
      ihe_pkg::ST_LN_MUL: begin
        mul_a = dvd[31:0];
        mul_b = ihe_pkg::LN2_Q32;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= {32'd0, mul_a} * {32'd0, mul_b};
  end

  // One restoring step of the divider.
  always_comb begin
    rem_shift = {rem[CW-1:0], dvd[DIVW-1]};
    if (rem_shift >= {1'b0, dsr}) begin
      rem_next = rem_shift - {1'b0, dsr};
      dvd_next = {dvd[DIVW-2:0], 1'b1};
    end else begin
      rem_next = rem_shift;
      dvd_next = {dvd[DIVW-2:0], 1'b0};
    end
  end

  // Squared mantissa back in Q2.30.
  assign mq    = prod[61:30];
  assign t_val = prod[DIVW-1:0];
  assign h_val = prod[63:32];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ihe_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ihe_pkg::ST_IDLE: begin
        if (start) begin
          state_next = (func == ihe_pkg::FUNC_READ) ? ihe_pkg::ST_RD : ihe_pkg::ST_ACC;
        end
      end
      ihe_pkg::ST_ACC:     state_next = last_q ? ihe_pkg::ST_E_ADDR : ihe_pkg::ST_IDLE;
      ihe_pkg::ST_RD:      state_next = (frame_pixels == '0) ? ihe_pkg::ST_IDLE : ihe_pkg::ST_DIV;
      ihe_pkg::ST_DIV: begin
        if (dcnt == '0) begin
          state_next = div_ent ? ihe_pkg::ST_LN_MUL : ihe_pkg::ST_IDLE;
        end
      end
      ihe_pkg::ST_E_ADDR:  state_next = ihe_pkg::ST_E_DATA;
      ihe_pkg::ST_E_DATA: begin
        if (cnt_now != '0 || idx == LAST_BIN) begin
          state_next = ihe_pkg::ST_LG_NORM;
        end else begin
          state_next = ihe_pkg::ST_E_ADDR;
        end
      end
      ihe_pkg::ST_LG_NORM: state_next = m[30] ? ihe_pkg::ST_LG_SQ : ihe_pkg::ST_LG_NORM;
      ihe_pkg::ST_LG_SQ:   state_next = ihe_pkg::ST_LG_BIT;
      ihe_pkg::ST_LG_BIT: begin
        if (k == '0) begin
          state_next = lg_total ? ihe_pkg::ST_NL_MUL : ihe_pkg::ST_CL_MUL;
        end else begin
          state_next = ihe_pkg::ST_LG_SQ;
        end
      end
      ihe_pkg::ST_CL_MUL:  state_next = ihe_pkg::ST_CL_ADD;
      ihe_pkg::ST_CL_ADD:  state_next = (idx == LAST_BIN) ? ihe_pkg::ST_LG_NORM : ihe_pkg::ST_E_ADDR;
      ihe_pkg::ST_NL_MUL:  state_next = ihe_pkg::ST_NL_SUB;
      ihe_pkg::ST_NL_SUB:  state_next = ihe_pkg::ST_DIV;
      ihe_pkg::ST_LN_MUL:  state_next = ihe_pkg::ST_LN_OUT;
      ihe_pkg::ST_LN_OUT:  state_next = ihe_pkg::ST_IDLE;
      default:             state_next = ihe_pkg::ST_IDLE;
    endcase
  end

  assign busy = (state != ihe_pkg::ST_IDLE);

  // Datapath and result registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_pixels <= '0;
      clamp_seen   <= 1'b0;
      frame_open   <= 1'b0;
      valid        <= '0;
      done         <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        ihe_pkg::ST_IDLE: begin
          if (start) begin
            addr <= (func == ihe_pkg::FUNC_READ) ? bin_index : pix_bin;
            if (func == ihe_pkg::FUNC_ACCUM) begin
              last_q <= last;
              // The first pixel of a frame clears the histogram through its
              // valid bits, along with the count and the clamp flag.
              if (!frame_open) begin
                valid        <= '0;
                frame_pixels <= '0;
                frame_open   <= 1'b1;
                clamp_seen   <= pix_clamp;
              end else if (pix_clamp) begin
                clamp_seen <= 1'b1;
              end
            end
          end
        end
        ihe_pkg::ST_ACC: begin
          // Past capacity a pixel is dropped from the count and histogram.
          if (frame_pixels < CW'(MAX_PIXELS)) begin
            valid[addr]  <= 1'b1;
            frame_pixels <= frame_pixels + CW'(1);
          end
          idx <= '0;
          sub <= '0;
        end
        ihe_pkg::ST_RD: begin
          if (frame_pixels == '0) begin
            done         <= 1'b1;
            kind         <= ihe_pkg::KIND_ANSWER;
            entropy      <= '0;
            out_of_range <= 1'b0;
            pixel_count  <= '0;
            probability  <= '0;
          end else begin
            dvd     <= DIVW'(cnt_now) << 16;
            rem     <= '0;
            dsr     <= frame_pixels;
            dcnt    <= DCW'(DIVW - 1);
            div_ent <= 1'b0;
          end
        end
        ihe_pkg::ST_DIV: begin
          dvd  <= dvd_next;
          rem  <= rem_next;
          dcnt <= dcnt - DCW'(1);
          if (dcnt == '0 && !div_ent) begin
            done         <= 1'b1;
            kind         <= ihe_pkg::KIND_ANSWER;
            entropy      <= '0;
            out_of_range <= 1'b0;
            pixel_count  <= ihe_pkg::COUNT_OUT_W'(frame_pixels);
            probability  <= dvd_next[ihe_pkg::PROB_W-1:0];
          end
        end
        ihe_pkg::ST_E_ADDR: begin
          addr <= idx;
        end
        ihe_pkg::ST_E_DATA: begin
          c_q <= cnt_now;
          if (cnt_now != '0) begin
            m        <= 31'(cnt_now);
            lg_e     <= 5'd30;
            lg_total <= 1'b0;
          end else if (idx == LAST_BIN) begin
            m        <= 31'(frame_pixels);
            lg_e     <= 5'd30;
            lg_total <= 1'b1;
          end else begin
            idx <= idx + ihe_pkg::BIN_W'(1);
          end
        end
        ihe_pkg::ST_LG_NORM: begin
          // Shift the leading one up to bit 30; the exponent tracks the shift.
          if (!m[30]) begin
            m    <= m << 1;
            lg_e <= lg_e - 5'd1;
          end else begin
            lg_f <= '0;
            k    <= 4'd15;
          end
        end
        ihe_pkg::ST_LG_BIT: begin
          if (mq[31]) begin
            lg_f[k] <= 1'b1;
            m       <= mq[31:1];
          end else begin
            m <= mq[30:0];
          end
          k <= k - 4'd1;
        end
        ihe_pkg::ST_CL_ADD: begin
          sub <= sub + t_val;
          if (idx == LAST_BIN) begin
            m        <= 31'(frame_pixels);
            lg_e     <= 5'd30;
            lg_total <= 1'b1;
          end else begin
            idx <= idx + ihe_pkg::BIN_W'(1);
          end
        end
        ihe_pkg::ST_NL_SUB: begin
          dvd     <= (t_val > sub) ? (t_val - sub) : '0;
          rem     <= '0;
          dsr     <= frame_pixels;
          dcnt    <= DCW'(DIVW - 1);
          div_ent <= 1'b1;
        end
        ihe_pkg::ST_LN_OUT: begin
          done         <= 1'b1;
          kind         <= ihe_pkg::KIND_SUMMARY;
          entropy      <= (h_val > 32'(ihe_pkg::ENTROPY_MAX)) ?
                          ihe_pkg::ENTROPY_W'(ihe_pkg::ENTROPY_MAX) : h_val[ihe_pkg::ENTROPY_W-1:0];
          out_of_range <= clamp_seen;
          pixel_count  <= ihe_pkg::COUNT_OUT_W'(frame_pixels);
          probability  <= '0;
          frame_open   <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

@@ design/ihe_checker.sv @@
// Port-level checks for the image histogram entropy block.
// Depends on ihe_pkg; bound to image_histogram_entropy below.
module ihe_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               start,
  input logic                               busy,
  input logic                               func,
  input logic signed [ihe_pkg::PIXEL_W-1:0] pixel,
  input logic                               last,
  input logic [ihe_pkg::BIN_W-1:0]          bin_index,
  input logic                               done,
  input logic                               kind,
  input logic [ihe_pkg::ENTROPY_W-1:0]      entropy,
  input logic                               out_of_range,
  input logic [ihe_pkg::COUNT_OUT_W-1:0]    pixel_count,
  input logic [ihe_pkg::PROB_W-1:0]         probability
);

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("accepted word did not raise busy");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("result strobed while still busy");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("two results in consecutive cycles");

  a_answer_fields: assert property (@(posedge clk) disable iff (rst)
    (done && kind == ihe_pkg::KIND_ANSWER) |->
      (entropy == '0 && !out_of_range && probability <= ihe_pkg::PROB_W'(ihe_pkg::ONE_Q16)))
    else $error("bad bin answer fields");

  a_summary_fields: assert property (@(posedge clk) disable iff (rst)
    (done && kind == ihe_pkg::KIND_SUMMARY) |->
      (probability == '0 && entropy <= ihe_pkg::ENTROPY_W'(ihe_pkg::ENTROPY_MAX)))
    else $error("bad frame summary fields");

endmodule

bind image_histogram_entropy ihe_checker u_ihe_checker (.*);

@@ tb/tb_top.sv @@
// Self-checking testbench for the image histogram entropy block.
// Depends on ihe_pkg and image_histogram_entropy from the design folder.
`timescale 1ns / 100ps

module tb_top;
  import ihe_pkg::*;

  logic                       clk;
  logic                       rst;
  logic                       start;
  logic                       busy;
  logic                       func;
  logic signed [PIXEL_W-1:0]  pixel;
  logic                       last;
  logic [BIN_W-1:0]           bin_index;
  logic                       done;
  logic                       kind;
  logic [ENTROPY_W-1:0]       entropy;
  logic                       out_of_range;
  logic [COUNT_OUT_W-1:0]     pixel_count;
  logic [PROB_W-1:0]          probability;

  // One expected result word, laid out as the output ports are.
  typedef struct {
    logic                   kind;
    logic [ENTROPY_W-1:0]   entropy;
    logic                   out_of_range;
    logic [COUNT_OUT_W-1:0] pixel_count;
    logic [PROB_W-1:0]      probability;
  } result_t;

  result_t expected_words[$];
  int      error_count;
  int      words_sent;
  int      words_checked;
  int      frames_closed;

  // Shadow copy of the block's histogram state.
  int unsigned hist[BIN_COUNT];
  int unsigned frame_total;
  bit          clamp_flag;
  bit          frame_active;

  image_histogram_entropy dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .func(func),
    .pixel(pixel), .last(last), .bin_index(bin_index), .done(done),
    .kind(kind), .entropy(entropy), .out_of_range(out_of_range),
    .pixel_count(pixel_count), .probability(probability)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // log2 of c in Q.16 by repeated squaring of the normalized mantissa.
  function automatic longint unsigned log2_q16(int unsigned c);
    int          e;
    longint unsigned m;
    longint unsigned r;
    e = 0;
    while (e < 31 && (c >> (e + 1)) != 0) e++;
    m = longint'(c) << (30 - e);
    r = longint'(e) << 16;
    for (int k = 15; k >= 0; k--) begin
      m = (m * m) >> 30;
      if (m >= (64'd2 << 30)) begin
        r |= 64'd1 << k;
        m >>= 1;
      end
    end
    return r;
  endfunction

  // Entropy in nats, Q3.16, of the shadow histogram.
  function automatic logic [ENTROPY_W-1:0] frame_entropy();
    longint unsigned n;
    longint unsigned t;
    longint unsigned sub;
    longint unsigned h2;
    logic [127:0]    wide;
    n = frame_total;
    sub = 0;
    if (n == 0) return '0;
    for (int i = 0; i < BIN_COUNT; i++)
      if (hist[i] != 0) sub += longint'(hist[i]) * log2_q16(hist[i]);
    t = n * log2_q16(frame_total);
    t = (t > sub) ? t - sub : 0;
    h2 = t / n;
    wide = (128'(h2) * 128'(LN2_Q32)) >> 32;
    if (wide > ENTROPY_MAX) wide = ENTROPY_MAX;
    return wide[ENTROPY_W-1:0];
  endfunction

  // Updates the shadow state for one word and queues any result it causes.
  task automatic predict_word(logic f, logic signed [PIXEL_W-1:0] px, logic lst,
                              logic [BIN_W-1:0] idx);
    result_t         r;
    int              y;
    longint unsigned p;
    if (f == FUNC_READ) begin
      p = 0;
      if (frame_total != 0) p = (longint'(hist[idx]) << 16) / frame_total;
      r.kind = KIND_ANSWER;
      r.entropy = '0;
      r.out_of_range = 1'b0;
      r.pixel_count = frame_total[COUNT_OUT_W-1:0];
      r.probability = p[PROB_W-1:0];
      expected_words.push_back(r);
      return;
    end
    if (!frame_active) begin
      foreach (hist[i]) hist[i] = 0;
      frame_total = 0;
      clamp_flag = 1'b0;
      frame_active = 1'b1;
    end
    y = px;
    if (y < 0) begin
      y = 0;
      clamp_flag = 1'b1;
    end
    if (y > ONE_Q16) begin
      y = ONE_Q16;
      clamp_flag = 1'b1;
    end
    if (frame_total < MAX_PIXELS) begin
      hist[(y * 255) >> 16]++;
      frame_total++;
    end
    if (!lst) return;
    r.kind = KIND_SUMMARY;
    r.entropy = frame_entropy();
    r.out_of_range = clamp_flag;
    r.pixel_count = frame_total[COUNT_OUT_W-1:0];
    r.probability = '0;
    expected_words.push_back(r);
    frame_active = 1'b0;
    frames_closed++;
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    $display("[%0t] %s: got %0d, expected %0d", $time, what, got, want);
    error_count++;
  endtask

  // Drives one word at the falling edge and holds it until the block takes it.
  // Back-to-back words keep start high, so it is never dropped and raised in
  // one step.
  task automatic send_word(logic f, logic signed [PIXEL_W-1:0] px, logic lst,
                           logic [BIN_W-1:0] idx);
    @(negedge clk);
    start <= 1'b1;
    func <= f;
    pixel <= px;
    last <= lst;
    bin_index <= idx;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_word(f, px, lst, idx);
    words_sent++;
  endtask

  task automatic go_quiet(int cycles);
    @(negedge clk);
    start <= 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  // Burst pacing: after a random number of words, the sender may pause a while.
  int burst_left;
  task automatic pace();
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    burst_left = $urandom_range(0, 12);
    if ($urandom_range(0, 3) != 0) go_quiet($urandom_range(1, 20));
  endtask

  task automatic send_pixel(logic signed [PIXEL_W-1:0] px, logic lst);
    send_word(FUNC_ACCUM, px, lst, BIN_W'($urandom));
  endtask

  task automatic send_read(logic [BIN_W-1:0] idx);
    send_word(FUNC_READ, PIXEL_W'($urandom), 1'($urandom), idx);
  endtask

  // Pixels mostly in range, with some past both ends of the clamp.
  function automatic logic signed [PIXEL_W-1:0] random_pixel();
    case ($urandom_range(0, 9))
      0: return PIXEL_W'($urandom);
      1: return PIXEL_W'($urandom_range(0, 8) == 0 ? ONE_Q16 : $urandom_range(0, 300));
      default: return PIXEL_W'($urandom_range(0, ONE_Q16));
    endcase
  endfunction

  // Every result word is compared with the oldest expectation.
  always @(posedge clk) begin
    result_t w;
    if (!rst && done) begin
      if (expected_words.size() == 0) begin
        report_mismatch("unexpected result word", kind, -1);
      end else begin
        w = expected_words.pop_front();
        if (kind !== w.kind) report_mismatch("kind", kind, w.kind);
        if (entropy !== w.entropy) report_mismatch("entropy", entropy, w.entropy);
        if (out_of_range !== w.out_of_range)
          report_mismatch("out_of_range", out_of_range, w.out_of_range);
        if (pixel_count !== w.pixel_count)
          report_mismatch("pixel_count", pixel_count, w.pixel_count);
        if (probability !== w.probability)
          report_mismatch("probability", probability, w.probability);
        words_checked++;
      end
    end
  end

  // Reads before any frame answer zero; then the extremes of the pixel field.
  task automatic test_empty_and_extremes();
    send_read(8'd0);
    send_read(8'd255);
    send_pixel(18'sh20000, 1'b0);
    send_pixel(18'sh1ffff, 1'b0);
    send_pixel(18'sd0, 1'b0);
    send_pixel(18'sd65536, 1'b0);
    send_pixel(18'sd65535, 1'b0);
    send_pixel(-18'sd1, 1'b0);
    send_read(8'd0);
    send_read(8'd255);
    send_read(8'd254);
    send_pixel(18'sd65537, 1'b1);
    send_read(8'd255);
    send_read(8'd0);
  endtask

  // A single-pixel frame with zero entropy, then uniform two-bin and four-bin frames.
  task automatic test_small_frames();
    send_pixel(18'sd32768, 1'b1);
    send_read(8'd127);
    send_pixel(18'sd0, 1'b0);
    send_pixel(18'sd65536, 1'b1);
    send_read(8'd255);
    for (int i = 0; i < 4; i++) send_pixel(18'(i * 16384), i == 3);
    send_read(8'd63);
  endtask

  // Random frames of mostly short length, interleaved with bin reads.
  task automatic test_random_frames(int words);
    int left;
    int k;
    left = words;
    while (left > 0) begin
      k = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
      for (int i = 0; i < k && left > 0; i++) begin
        pace();
        if ($urandom_range(0, 5) == 0) send_read(BIN_W'($urandom));
        else send_pixel(random_pixel(), i == k - 1);
        left--;
      end
    end
    send_pixel(random_pixel(), 1'b1);
  endtask

  int wait_cycles;
  initial begin
    rst = 1'b1;
    start = 1'b0;
    func = FUNC_ACCUM;
    pixel = '0;
    last = 1'b0;
    bin_index = '0;
    error_count = 0;
    words_sent = 0;
    words_checked = 0;
    frames_closed = 0;
    burst_left = 0;
    frame_total = 0;
    clamp_flag = 1'b0;
    frame_active = 1'b0;
    foreach (hist[i]) hist[i] = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_empty_and_extremes();
    test_small_frames();
    test_random_frames(450);
    go_quiet(1);

    // Every word yields at most one result, so drain the queue, then idle a
    // summary's worth of cycles to catch stray words.
    wait_cycles = 0;
    while (expected_words.size() != 0 && wait_cycles < 200000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (20000) @(posedge clk);

    $display("Sent %0d words across %0d frames; %0d result words checked.",
             words_sent, frames_closed, words_checked);
    if (error_count == 0 && expected_words.size() == 0) begin
      $display("image_histogram_entropy: match");
    end else begin
      $display("Mismatches: %0d, results still owed: %0d", error_count,
               expected_words.size());
      $display("image_histogram_entropy: mismatch");
    end
    $finish;
  end

  // Watchdog: a hung run ends here as a mismatch, well past the worst-case summary.
  initial begin
    #200ms;
    $display("image_histogram_entropy: mismatch");
    $finish;
  end

endmodule

@@ sim.f @@
design/ihe_pkg.sv
design/ihe_ram.sv
design/image_histogram_entropy.sv
design/ihe_checker.sv
tb/tb_top.sv
